// File: design/hcr_pkg.sv
// Shared types, constants and colour tables for the height-to-colour ramp.
// Used by hcr_front, hcr_divider and height_to_color_ramp_core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

  localparam int HEIGHT_W  = 18;  // signed Q1.16 sample
  localparam int THR_W     = 17;  // unsigned Q16 threshold, 0..65536
  localparam int NUM_THR   = 5;
  localparam int NUM_CH    = 3;   // index 0 red, 1 green, 2 blue
  localparam int CH_W      = 8;
  localparam int SPAN_W    = 7;   // largest span is 100
  localparam int Q_W       = 7;   // quotient never exceeds the span
  localparam int NUM_W     = THR_W + SPAN_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = THR_W;

  localparam logic [THR_W-1:0] FULL_SCALE = THR_W'(65536);

  localparam logic [THR_W-1:0] SEA_LEVEL_RST    = THR_W'(26214);
  localparam logic [THR_W-1:0] BEACH_END_RST    = THR_W'(29491);
  localparam logic [THR_W-1:0] PLAINS_END_RST   = THR_W'(39322);
  localparam logic [THR_W-1:0] FOREST_END_RST   = THR_W'(49152);
  localparam logic [THR_W-1:0] MOUNTAIN_END_RST = THR_W'(58982);

  typedef enum logic [2:0] {
    BAND_OCEAN    = 3'd0,
    BAND_BEACH    = 3'd1,
    BAND_PLAINS   = 3'd2,
    BAND_FOREST   = 3'd3,
    BAND_MOUNTAIN = 3'd4,
    BAND_SNOW     = 3'd5
  } band_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEA_LEVEL    = 3'd0,
    REG_BEACH_END    = 3'd1,
    REG_PLAINS_END   = 3'd2,
    REG_FOREST_END   = 3'd3,
    REG_MOUNTAIN_END = 3'd4
  } cfg_reg_t;

  typedef logic [NUM_THR-1:0][THR_W-1:0] thr_t;

  // Front end to divider: band, divisor and the three scaled numerators.
  typedef struct packed {
    band_t                          band;
    logic [THR_W-1:0]               den;
    logic [NUM_CH-1:0][NUM_W-1:0]   num;
  } div_in_t;

  typedef struct packed {
    band_t                          band;
    logic [NUM_CH-1:0][Q_W-1:0]     quo;
  } div_out_t;

  // Colour tables, packed as {blue, green, red}.
  function automatic logic [NUM_CH-1:0][CH_W-1:0] band_base(band_t b);
    logic [NUM_CH-1:0][CH_W-1:0] r;
    case (b)
      BAND_OCEAN:    r = {8'd80,  8'd20,  8'd0};
      BAND_BEACH:    r = {8'd100, 8'd190, 8'd200};
      BAND_PLAINS:   r = {8'd50,  8'd150, 8'd100};
      BAND_FOREST:   r = {8'd30,  8'd90,  8'd30};
      BAND_MOUNTAIN: r = {8'd100, 8'd105, 8'd110};
      BAND_SNOW:     r = {8'd230, 8'd230, 8'd230};
      default:       r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [NUM_CH-1:0][SPAN_W-1:0] band_span(band_t b);
    logic [NUM_CH-1:0][SPAN_W-1:0] r;
    case (b)
      BAND_OCEAN:    r = {7'd100, 7'd40, 7'd0};
      BAND_BEACH:    r = {7'd80,  7'd40, 7'd55};
      BAND_PLAINS:   r = {7'd30,  7'd70, 7'd60};
      BAND_FOREST:   r = {7'd30,  7'd60, 7'd40};
      BAND_MOUNTAIN: r = {7'd30,  7'd35, 7'd40};
      BAND_SNOW:     r = {7'd25,  7'd25, 7'd25};
      default:       r = '0;
    endcase
    return r;
  endfunction

  // Channels that ramp downwards: only beach blue.
  function automatic logic [NUM_CH-1:0] band_down(band_t b);
    logic [NUM_CH-1:0] r;
    case (b)
      BAND_BEACH: r = 3'b100;
      default:    r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/hcr_front.sv
// Front end: clamp, band search, then offset, divisor and span products.
// Two register stages. Depends on hcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcr_front (
  input  wire logic                                clk,
  input  wire logic [1:0]                          en,
  input  wire logic signed [hcr_pkg::HEIGHT_W-1:0] height,
  input  wire hcr_pkg::thr_t                       thr,
  output hcr_pkg::div_in_t                         dout
);

  localparam int TW = hcr_pkg::THR_W;
  localparam int NW = hcr_pkg::NUM_W;

  logic [TW-1:0]           h_clamp;
  logic [TW-1:0]           low_sel;
  logic [TW-1:0]           high_sel;
  hcr_pkg::band_t          band_sel;
  logic                    found;

  logic [TW-1:0]           h1;
  logic [TW-1:0]           low1;
  logic [TW-1:0]           high1;
  hcr_pkg::band_t          band1;

  logic [TW-1:0]           off;
  logic [TW-1:0]           den;
  logic [hcr_pkg::NUM_CH-1:0][hcr_pkg::SPAN_W-1:0] span;
  hcr_pkg::div_in_t        dout_next;

  // Stage 1: clamp to 0..1.0 and take the first threshold above the height.
  always_comb begin
    if (height[hcr_pkg::HEIGHT_W-1]) begin
      h_clamp = '0;
    end else if (height[TW-1:0] > hcr_pkg::FULL_SCALE) begin
      h_clamp = hcr_pkg::FULL_SCALE;
    end else begin
      h_clamp = height[TW-1:0];
    end

    band_sel = hcr_pkg::BAND_SNOW;
    low_sel  = '0;
    high_sel = hcr_pkg::FULL_SCALE;
    found    = 1'b0;
    for (int i = 0; i < hcr_pkg::NUM_THR; i++) begin
      if (!found) begin
        if (h_clamp < thr[i]) begin
          band_sel = hcr_pkg::band_t'(3'(i));
          high_sel = thr[i];
          found    = 1'b1;
        end else begin
          low_sel = thr[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1    <= h_clamp;
      low1  <= low_sel;
      high1 <= high_sel;
      band1 <= band_sel;
    end
  end

  // Stage 2: numerators off*span; an empty snow band divides 0 by 1.
  always_comb begin
    off  = h1 - low1;
    den  = high1 - low1;
    span = hcr_pkg::band_span(band1);
    dout_next.band = band1;
    dout_next.den  = (den == '0) ? TW'(1) : den;
    for (int c = 0; c < hcr_pkg::NUM_CH; c++) begin
      dout_next.num[c] = (den == '0) ? '0 : NW'(NW'(off) * NW'(span[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

// File: design/hcr_divider.sv
// Pipelined restoring divider: one quotient bit per stage, three channels
// side by side sharing one divisor. Depends on hcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcr_divider (
  input  wire logic [hcr_pkg::Q_W-1:0] en,
  input  wire logic                    clk,
  input  wire hcr_pkg::div_in_t        din,
  output hcr_pkg::div_out_t            dout
);

  localparam int QW = hcr_pkg::Q_W;
  localparam int NW = hcr_pkg::NUM_W;

  typedef struct packed {
    hcr_pkg::band_t                              band;
    logic [hcr_pkg::THR_W-1:0]                   den;
    logic [hcr_pkg::NUM_CH-1:0][NW-1:0]          rem;
    logic [hcr_pkg::NUM_CH-1:0][QW-1:0]          quo;
  } step_t;

  step_t st [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int SH = QW - 1 - s;
    step_t         cur;
    step_t         nxt;
    logic [NW-1:0] trial;

    if (s == 0) begin : g_first
      always_comb begin
        cur.band = din.band;
        cur.den  = din.den;
        cur.rem  = din.num;
        cur.quo  = '0;
      end
    end else begin : g_rest
      assign cur = st[s-1];
    end

    // Take the shifted divisor off wherever it fits.
    always_comb begin
      nxt   = cur;
      trial = NW'(cur.den) << SH;
      for (int c = 0; c < hcr_pkg::NUM_CH; c++) begin
        if (cur.rem[c] >= trial) begin
          nxt.rem[c]     = cur.rem[c] - trial;
          nxt.quo[c][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st[s] <= nxt;
      end
    end
  end

  assign dout.band = st[QW-1].band;
  assign dout.quo  = st[QW-1].quo;

endmodule

`default_nettype wire

// File: design/height_to_color_ramp_core.sv
// Height to colour ramp, top level: config registers, pipeline control
// and the output stage. Depends on hcr_pkg, hcr_front and hcr_divider.
//
// Usage:
//   Input channel in_valid/in_stall carries one signed Q1.16 height per
//   beat; output channel out_valid/out_stall carries band and RGB.
//   The pipeline is ten register stages: clamp and band search, offset
//   and span multiply, seven stages of a restoring divider (one quotient
//   bit each), and the output register that adds the band base colour.
//   Throughput is one beat per cycle while out_stall is low.
//   Each stage holds its own valid bit and moves whenever the stage after
//   it is empty or moving, so bubbles close up under stall. in_stall
//   rises only when all ten stages are full and out_stall is high.
//   A stalled output holds its beat unchanged.
//   Reset clears every valid bit and loads the default thresholds.
//   Threshold writes on cfg_write/cfg_index/cfg_data take effect at once
//   and are meant to happen only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module height_to_color_ramp_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [hcr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [hcr_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [hcr_pkg::HEIGHT_W-1:0]  height,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [2:0]                                band,
  output logic [hcr_pkg::CH_W-1:0]                  red,
  output logic [hcr_pkg::CH_W-1:0]                  green,
  output logic [hcr_pkg::CH_W-1:0]                  blue
);

  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = hcr_pkg::Q_W;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;
  localparam int CW           = hcr_pkg::CH_W;

  hcr_pkg::thr_t            thr;
  logic [NUM_STAGES-1:0]    vld;
  logic [NUM_STAGES-1:0]    en;
  hcr_pkg::div_in_t         div_in;
  hcr_pkg::div_out_t        div_out;
  logic [hcr_pkg::NUM_CH-1:0][CW-1:0] base;
  logic [hcr_pkg::NUM_CH-1:0]         down;
  logic [hcr_pkg::NUM_CH-1:0][CW-1:0] color_next;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr[hcr_pkg::REG_SEA_LEVEL]    <= hcr_pkg::SEA_LEVEL_RST;
      thr[hcr_pkg::REG_BEACH_END]    <= hcr_pkg::BEACH_END_RST;
      thr[hcr_pkg::REG_PLAINS_END]   <= hcr_pkg::PLAINS_END_RST;
      thr[hcr_pkg::REG_FOREST_END]   <= hcr_pkg::FOREST_END_RST;
      thr[hcr_pkg::REG_MOUNTAIN_END] <= hcr_pkg::MOUNTAIN_END_RST;
    end else if (cfg_write) begin
      unique case (hcr_pkg::cfg_reg_t'(cfg_index))
        hcr_pkg::REG_SEA_LEVEL:    thr[hcr_pkg::REG_SEA_LEVEL]    <= cfg_data;
        hcr_pkg::REG_BEACH_END:    thr[hcr_pkg::REG_BEACH_END]    <= cfg_data;
        hcr_pkg::REG_PLAINS_END:   thr[hcr_pkg::REG_PLAINS_END]   <= cfg_data;
        hcr_pkg::REG_FOREST_END:   thr[hcr_pkg::REG_FOREST_END]   <= cfg_data;
        hcr_pkg::REG_MOUNTAIN_END: thr[hcr_pkg::REG_MOUNTAIN_END] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its own beat moves on.
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  hcr_front u_front (
    .clk    (clk),
    .en     (en[FRONT_STAGES-1:0]),
    .height (height),
    .thr    (thr),
    .dout   (div_in)
  );

  hcr_divider u_divider (
    .en   (en[FRONT_STAGES +: DIV_STAGES]),
    .clk  (clk),
    .din  (div_in),
    .dout (div_out)
  );

  // Output stage: base plus or minus the scaled offset, kept to 8 bits.
  always_comb begin
    base = hcr_pkg::band_base(div_out.band);
    down = hcr_pkg::band_down(div_out.band);
    for (int c = 0; c < hcr_pkg::NUM_CH; c++) begin
      color_next[c] = down[c] ? base[c] - CW'(div_out.quo[c])
                              : base[c] + CW'(div_out.quo[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      band  <= div_out.band;
      red   <= color_next[0];
      green <= color_next[1];
      blue  <= color_next[2];
    end
  end

  // Input may only stall when the whole pipeline is full and held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (&vld)))
    else $error("input stalled with room in the pipeline");

  // An accepted beat occupies the first stage on the next edge.
  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted beat lost at the first stage");

  // Snow ramps all three channels alike.
  a_snow_grey: assert property (@(posedge clk) disable iff (rst)
    (out_valid && band == hcr_pkg::BAND_SNOW) |-> (red == green && green == blue))
    else $error("snow band colour is not grey");

  // Ocean has no red at any depth.
  a_ocean_red: assert property (@(posedge clk) disable iff (rst)
    (out_valid && band == hcr_pkg::BAND_OCEAN) |-> (red == '0))
    else $error("ocean band has a red component");

endmodule

`default_nettype wire
